>>> src/cmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmu_pkg;

  typedef enum logic [2:0] {
    ACT_MCRF   = 3'd0,
    ACT_MFCR   = 3'd1,
    ACT_MFOCRF = 3'd2,
    ACT_MTCRF  = 3'd3,
    ACT_MTOCRF = 3'd4,
    ACT_MTMSR  = 3'd5,
    ACT_MTMSRD = 3'd6
  } action_t;

  localparam int CR_WIDTH    = 32;
  localparam int MSR_WIDTH   = 64;
  localparam int GPR_WIDTH   = 64;
  localparam int CR_FIELDS   = 8;
  localparam int FIELD_WIDTH = 4;
  localparam int MSR_PR_BIT  = 14;

  localparam logic [FIELD_WIDTH-1:0] NIBBLE_MASK   = 4'hf;
  localparam logic [MSR_WIDTH-1:0]   MSR_PART_MASK = 64'h0000_0000_0000_fffe;

  typedef struct packed {
    logic [2:0]           action;
    logic [2:0]           dest_field;
    logic [2:0]           src_field;
    logic [7:0]           field_mask;
    logic [4:0]           reg_index;
    logic [GPR_WIDTH-1:0] reg_value;
    logic                 l_bit;
  } item_t;

  typedef struct packed {
    logic                 reg_write;
    logic [4:0]           write_index;
    logic [GPR_WIDTH-1:0] write_value;
  } wb_t;

  // Expand an 8-bit field mask to CR bits; mask bit 7 selects field 0
  // (top nibble), so mask bit k covers CR bits 4k+3..4k.
  function automatic logic [CR_WIDTH-1:0] mask_bits(input logic [7:0] fm);
    logic [CR_WIDTH-1:0] m;
    m = '0;
    for (int k = 0; k < CR_FIELDS; k++) begin
      m[k*FIELD_WIDTH +: FIELD_WIDTH] = fm[k] ? NIBBLE_MASK : '0;
    end
    return m;
  endfunction

  function automatic logic one_bit(input logic [7:0] fm);
    return (fm != 8'd0) && ((fm & (fm - 8'd1)) == 8'd0);
  endfunction

  // Full MSR write: PR is copied into bits 5 and 4.
  function automatic logic [MSR_WIDTH-1:0] msr_full(input logic [MSR_WIDTH-1:0] s);
    logic [MSR_WIDTH-1:0] pr;
    pr = {{(MSR_WIDTH-1){1'b0}}, s[MSR_PR_BIT]};
    return s | (pr << 5) | (pr << 4);
  endfunction

endpackage
`default_nettype wire

>>> src/cr_msr_move_unit_top.sv
// CR / MSR move unit.
// Input channel: in_valid / in_stall carry one instruction beat (action,
// CR field selectors, field mask, GPR index and GPR value read).
// Output channel: out_valid / out_stall carry one result beat per input
// beat: GPR write-back (reg_write, write_index, write_value) plus the CR
// and MSR as they stand after that instruction.
// Stages: two register stages, the input register and then the result
// register; a beat moves on from the first when the result register frees.
// Throughput: one beat per cycle while the output is not stalled; the only
// logic between the stages is the CR mask/merge, MSR merge and GPR
// write-back select in cmu_exec, and the CR/MSR state is updated in the
// same cycle an instruction moves to the result register, so the next instruction sees it right away.
// Reset (rst, synchronous): both stages empty, CR and MSR cleared.
// Stall: while out_stall holds a result, the input register keeps its
// beat and in_stall rises only if that register is full; the held result
// and the architectural state do not change.
`timescale 1ns / 1ps
`default_nettype none
module cr_msr_move_unit_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [2:0]                        action,
  input  wire  [2:0]                        dest_field,
  input  wire  [2:0]                        src_field,
  input  wire  [7:0]                        field_mask,
  input  wire  [4:0]                        reg_index,
  input  wire  [cmu_pkg::GPR_WIDTH-1:0]     reg_value,
  input  wire                               l_bit,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              reg_write,
  output logic [4:0]                        write_index,
  output logic [cmu_pkg::GPR_WIDTH-1:0]     write_value,
  output logic [cmu_pkg::CR_WIDTH-1:0]      cr_now,
  output logic [cmu_pkg::MSR_WIDTH-1:0]     msr_now
);
  import cmu_pkg::*;

  // Input register
  logic  stage_valid;
  item_t stage_item;

  // Architectural state
  logic [CR_WIDTH-1:0]  cr;
  logic [MSR_WIDTH-1:0] msr;

  logic [CR_WIDTH-1:0]  cr_next;
  logic [MSR_WIDTH-1:0] msr_next;
  wb_t                  wb;

  logic advance;
  logic in_take;

  // Result register can take a beat when empty or being drained.
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  cmu_exec u_exec (
    .item     (stage_item),
    .cr       (cr),
    .msr      (msr),
    .wb       (wb),
    .cr_next  (cr_next),
    .msr_next (msr_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item.action     <= action;
      stage_item.dest_field <= dest_field;
      stage_item.src_field  <= src_field;
      stage_item.field_mask <= field_mask;
      stage_item.reg_index  <= reg_index;
      stage_item.reg_value  <= reg_value;
      stage_item.l_bit      <= l_bit;
    end
  end

  // CR and MSR commit as the instruction leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cr  <= '0;
      msr <= '0;
    end else if (advance) begin
      cr  <= cr_next;
      msr <= msr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reg_write   <= wb.reg_write;
      write_index <= wb.write_index;
      write_value <= wb.write_value;
      cr_now      <= cr_next;
      msr_now     <= msr_next;
    end
  end

endmodule
`default_nettype wire

>>> src/cmu_exec.sv
`timescale 1ns / 1ps
`default_nettype none
module cmu_exec (
  input  wire  cmu_pkg::item_t                     item,
  input  logic [cmu_pkg::CR_WIDTH-1:0]             cr,
  input  logic [cmu_pkg::MSR_WIDTH-1:0]            msr,
  output cmu_pkg::wb_t                             wb,
  output logic [cmu_pkg::CR_WIDTH-1:0]             cr_next,
  output logic [cmu_pkg::MSR_WIDTH-1:0]            msr_next
);
  import cmu_pkg::*;

  logic [CR_WIDTH-1:0]    fmask;
  logic                   single;
  logic [2:0]             src_slot;
  logic [FIELD_WIDTH-1:0] src_nib;
  logic [CR_WIDTH-1:0]    mcrf_cr;

  assign fmask  = mask_bits(item.field_mask);
  assign single = one_bit(item.field_mask);

  // Field n lives at nibble slot 7-n, i.e. ~n for a 3-bit field number.
  assign src_slot = ~item.src_field;
  assign src_nib  = cr[src_slot*FIELD_WIDTH +: FIELD_WIDTH];

  always_comb begin
    mcrf_cr = cr;
    for (int k = 0; k < CR_FIELDS; k++) begin
      if (3'(k) == ~item.dest_field) begin
        mcrf_cr[k*FIELD_WIDTH +: FIELD_WIDTH] = src_nib;
      end
    end
  end

  always_comb begin
    cr_next         = cr;
    msr_next        = msr;
    wb.reg_write    = 1'b0;
    wb.write_index  = '0;
    wb.write_value  = '0;
    case (action_t'(item.action))
      ACT_MCRF: begin
        cr_next = mcrf_cr;
      end
      ACT_MFCR: begin
        wb.reg_write   = 1'b1;
        wb.write_index = item.reg_index;
        wb.write_value = {{(GPR_WIDTH-CR_WIDTH){1'b0}}, cr};
      end
      ACT_MFOCRF: begin
        if (single) begin
          wb.reg_write   = 1'b1;
          wb.write_index = item.reg_index;
          wb.write_value = (item.reg_value & ~{{(GPR_WIDTH-CR_WIDTH){1'b0}}, fmask})
                         | {{(GPR_WIDTH-CR_WIDTH){1'b0}}, cr & fmask};
        end
      end
      ACT_MTCRF: begin
        cr_next = (cr & ~fmask) | (item.reg_value[CR_WIDTH-1:0] & fmask);
      end
      ACT_MTOCRF: begin
        if (single) begin
          cr_next = (cr & ~fmask) | (item.reg_value[CR_WIDTH-1:0] & fmask);
        end
      end
      ACT_MTMSR: begin
        msr_next = item.l_bit ? item.reg_value : msr_full(item.reg_value);
      end
      ACT_MTMSRD: begin
        msr_next = item.l_bit
                 ? ((msr & ~MSR_PART_MASK) | (item.reg_value & MSR_PART_MASK))
                 : msr_full(item.reg_value);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
